/* rtl/rsst_pkg.sv */
// shared types and constants for the region shadow state table
package rsst_pkg;

  localparam int DEF_SLOTS     = 8;
  localparam int DEF_MAX_BYTES = 4096;
  localparam int DEF_ADDR_BITS = 48;

  localparam int LANES   = 16;
  localparam int LANE_SH = 4;
  localparam int WORD_W  = 32;

  localparam int MODE_W   = 3;
  localparam int IN_ADDR_W = 48;
  localparam int LEN_W    = 13;
  localparam int STATE_W  = 2;
  localparam int STATUS_W = 2;

  localparam logic [STATE_W-1:0]  STATE_MASK  = 2'h3;
  localparam logic [STATE_W-1:0]  ST_REDZONE  = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_CLIP = 2'd2;

  typedef enum logic [MODE_W-1:0] {
    MODE_REG       = 3'd0,
    MODE_UNREG     = 3'd1,
    MODE_SET_BYTE  = 3'd2,
    MODE_SET_RANGE = 3'd3,
    MODE_GET       = 3'd4,
    MODE_COUNT     = 3'd5,
    MODE_CLEAR     = 3'd6
  } mode_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_WALK,
    S_FIN
  } seq_state_t;

  typedef struct packed {
    logic scan;
    logic wr;
    logic del;
    logic clr_all;
  } slot_cmd_t;

  typedef struct packed {
    logic done;
    logic found_v;
    logic free_v;
    logic hit_v;
  } scan_res_t;

endpackage

/* rtl/rsst_ram.sv */
// generic single write, single registered read memory
module rsst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/rsst_slots.sv */
// region slot table with a one-slot-per-cycle lookup scan
module rsst_slots #(
  parameter int SLOTS     = rsst_pkg::DEF_SLOTS,
  parameter int MAX_BYTES = rsst_pkg::DEF_MAX_BYTES,
  parameter int ADDR_BITS = rsst_pkg::DEF_ADDR_BITS
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  rsst_pkg::slot_cmd_t                         cmd,
  input  logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0]  cmd_idx,
  input  logic [ADDR_BITS-1:0]                        cmd_addr,
  input  logic [$clog2(MAX_BYTES):0]                  cmd_size,
  output rsst_pkg::scan_res_t                         res,
  output logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0]  found_idx,
  output logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0]  free_idx,
  output logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0]  hit_idx,
  output logic [$clog2(MAX_BYTES):0]                  hit_size,
  output logic [$clog2(MAX_BYTES):0]                  hit_off
);
  import rsst_pkg::*;

  localparam int SI_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int OFF_W = $clog2(MAX_BYTES) + 1;
  localparam logic [SI_W-1:0] LAST = SI_W'(SLOTS - 1);

  logic                 valid [SLOTS];
  logic [ADDR_BITS-1:0] base  [SLOTS];
  logic [OFF_W-1:0]     size  [SLOTS];

  logic                 busy;
  logic [SI_W-1:0]      scan_i;
  logic [ADDR_BITS-1:0] hit_base;

  logic                 cur_valid;
  logic [ADDR_BITS-1:0] cur_base;
  logic [OFF_W-1:0]     cur_size;
  logic [ADDR_BITS-1:0] diff;
  logic                 inreg;

  // shared compare unit
  always_comb begin
    cur_valid = valid[scan_i];
    cur_base  = base[scan_i];
    cur_size  = size[scan_i];
    diff      = cmd_addr - cur_base;
    inreg     = cur_valid && (cmd_addr >= cur_base) && (64'(diff) < 64'(cur_size));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < SLOTS; s++) begin
        valid[s] <= 1'b0;
      end
      busy     <= 1'b0;
      res      <= '0;
      scan_i   <= '0;
    end else begin
      res.done <= 1'b0;
      if (cmd.clr_all) begin
        for (int s = 0; s < SLOTS; s++) begin
          valid[s] <= 1'b0;
        end
      end
      if (cmd.wr) begin
        valid[cmd_idx] <= 1'b1;
        base[cmd_idx]  <= cmd_addr;
        size[cmd_idx]  <= cmd_size;
      end
      if (cmd.del) begin
        valid[cmd_idx] <= 1'b0;
      end
      if (cmd.scan) begin
        busy        <= 1'b1;
        scan_i      <= '0;
        res.found_v <= 1'b0;
        res.free_v  <= 1'b0;
        res.hit_v   <= 1'b0;
      end else if (busy) begin
        if (!res.found_v && cur_valid && cur_base == cmd_addr) begin
          res.found_v <= 1'b1;
          found_idx   <= scan_i;
        end
        if (!res.free_v && !cur_valid) begin
          res.free_v <= 1'b1;
          free_idx   <= scan_i;
        end
        if (inreg && (!res.hit_v || cur_base < hit_base)) begin
          res.hit_v <= 1'b1;
          hit_idx   <= scan_i;
          hit_base  <= cur_base;
          hit_size  <= cur_size;
          hit_off   <= OFF_W'(diff);
        end
        if (scan_i == LAST) begin
          busy     <= 1'b0;
          res.done <= 1'b1;
        end else begin
          scan_i <= scan_i + 1'b1;
        end
      end
    end
  end

endmodule

/* rtl/rsst_seq.sv */
// item sequencer and shadow word walker
module rsst_seq #(
  parameter int SLOTS     = rsst_pkg::DEF_SLOTS,
  parameter int MAX_BYTES = rsst_pkg::DEF_MAX_BYTES,
  parameter int ADDR_BITS = rsst_pkg::DEF_ADDR_BITS,
  parameter int RA_W      = 11
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        in_valid,
  output logic                                        in_ready,
  input  rsst_pkg::mode_t                             in_mode,
  input  logic [ADDR_BITS-1:0]                        in_addr,
  input  logic [$clog2(MAX_BYTES):0]                  in_len,
  input  logic [rsst_pkg::STATE_W-1:0]                in_state,
  input  logic                                        in_clip,
  output rsst_pkg::slot_cmd_t                         cmd,
  output logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0]  cmd_idx,
  output logic [ADDR_BITS-1:0]                        cmd_addr,
  output logic [$clog2(MAX_BYTES):0]                  cmd_size,
  input  rsst_pkg::scan_res_t                         scan,
  input  logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0]  found_idx,
  input  logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0]  free_idx,
  input  logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0]  hit_idx,
  input  logic [$clog2(MAX_BYTES):0]                  hit_size,
  input  logic [$clog2(MAX_BYTES):0]                  hit_off,
  output logic                                        ram_we,
  output logic [RA_W-1:0]                             ram_waddr,
  output logic [rsst_pkg::WORD_W-1:0]                 ram_wdata,
  output logic [RA_W-1:0]                             ram_raddr,
  input  logic [rsst_pkg::WORD_W-1:0]                 ram_rdata,
  input  logic                                        res_ready,
  output logic                                        res_valid,
  output logic [rsst_pkg::STATE_W-1:0]                res_state,
  output logic [rsst_pkg::LEN_W-1:0]                  res_count,
  output logic                                        res_hit,
  output logic [rsst_pkg::STATUS_W-1:0]               res_status
);
  import rsst_pkg::*;

  localparam int SI_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int MAX_W = $clog2(MAX_BYTES);
  localparam int OFF_W = MAX_W + 1;
  localparam int WI_W  = (MAX_W > LANE_SH) ? MAX_W - LANE_SH : 1;
  localparam int WPS   = MAX_BYTES / LANES;

  seq_state_t state, state_next;

  mode_t               mode_r;
  logic [ADDR_BITS-1:0] addr_r;
  logic [STATE_W-1:0]  st_r;
  logic [OFF_W-1:0]    len_r;
  logic [SI_W-1:0]     slot_r;
  logic [OFF_W-1:0]    off_s;
  logic [OFF_W-1:0]    off_e;
  logic [WI_W-1:0]     rw;
  logic [WI_W-1:0]     w_last;
  logic                issuing;
  logic                p_valid;
  logic [WI_W-1:0]     p_w;
  logic                hit_r;
  logic [STATUS_W-1:0] status_r;
  logic [STATE_W-1:0]  rd_r;
  logic [OFF_W-1:0]    cnt_r;

  logic [OFF_W:0]      sum;
  logic [OFF_W-1:0]    walk_s;
  logic [OFF_W-1:0]    walk_e;
  logic                walk_go;
  logic                slot_ok;
  logic [LANES-1:0]    lane_m;
  logic [OFF_W-1:0]    pos;
  logic [LANE_SH:0]    pop;
  logic                is_set;

  assign in_ready = (state == S_IDLE);
  assign slot_ok  = scan.found_v || scan.free_v;
  assign is_set   = (mode_r == MODE_REG) || (mode_r == MODE_SET_BYTE)
                 || (mode_r == MODE_SET_RANGE);

  // range setup from scan result
  always_comb begin
    sum    = (OFF_W+1)'(hit_off) + (OFF_W+1)'(len_r);
    walk_s = hit_off;
    walk_e = hit_off;
    walk_go = 1'b0;
    unique case (mode_r)
      MODE_REG: begin
        walk_s  = '0;
        walk_e  = len_r;
        walk_go = slot_ok && (len_r != '0);
      end
      MODE_SET_BYTE, MODE_GET: begin
        walk_e  = hit_off + 1'b1;
        walk_go = scan.hit_v;
      end
      MODE_SET_RANGE, MODE_COUNT: begin
        walk_e  = (sum > (OFF_W+1)'(hit_size)) ? hit_size : OFF_W'(sum);
        walk_go = scan.hit_v && (walk_e > walk_s);
      end
      default: begin
        walk_go = 1'b0;
      end
    endcase
  end

  // lanes of the word in hand
  always_comb begin
    pop = '0;
    for (int l = 0; l < LANES; l++) begin
      pos       = OFF_W'({p_w, LANE_SH'(l)});
      lane_m[l] = (pos >= off_s) && (pos < off_e);
      ram_wdata[l*STATE_W +: STATE_W] = lane_m[l] ? st_r
                                               : ram_rdata[l*STATE_W +: STATE_W];
      if (lane_m[l] && (ram_rdata[l*STATE_W +: STATE_W] & STATE_MASK) != ST_REDZONE) begin
        pop = pop + 1'b1;
      end
    end
  end

  always_comb begin
    ram_raddr = RA_W'(32'(slot_r) * WPS + 32'(rw));
    ram_waddr = RA_W'(32'(slot_r) * WPS + 32'(p_w));
    ram_we    = (state == S_WALK) && p_valid && is_set;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = (in_mode == MODE_CLEAR || !(in_mode == MODE_REG
                        || in_mode == MODE_UNREG || in_mode == MODE_SET_BYTE
                        || in_mode == MODE_SET_RANGE || in_mode == MODE_GET
                        || in_mode == MODE_COUNT)) ? S_FIN : S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan.done) begin
          state_next = walk_go ? S_WALK : S_FIN;
        end
      end
      S_WALK: begin
        if (!issuing && !p_valid) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd       = '0;
    cmd_idx   = scan.found_v ? found_idx : free_idx;
    cmd_addr  = in_ready ? in_addr : '0;
    cmd_addr  = state == S_IDLE ? in_addr : cmd_addr;
    cmd_size  = len_r;
    res_valid = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.clr_all = (in_mode == MODE_CLEAR);
          cmd.scan    = (in_mode == MODE_REG) || (in_mode == MODE_UNREG)
                     || (in_mode == MODE_SET_BYTE) || (in_mode == MODE_SET_RANGE)
                     || (in_mode == MODE_GET) || (in_mode == MODE_COUNT);
        end
      end
      S_SCAN: begin
        if (scan.done) begin
          cmd.wr  = (mode_r == MODE_REG) && slot_ok;
          cmd.del = (mode_r == MODE_UNREG) && scan.found_v;
        end
      end
      S_WALK: begin
        cmd = '0;
      end
      S_FIN: begin
        res_valid = res_ready;
      end
      default: begin
        cmd = '0;
      end
    endcase
    if (state != S_IDLE) begin
      cmd_addr = addr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      issuing <= 1'b0;
      p_valid <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            mode_r   <= in_mode;
            addr_r   <= in_addr;
            len_r    <= in_len;
            st_r     <= in_state;
            hit_r    <= 1'b0;
            status_r <= in_clip ? STATUS_CLIP : STATUS_OK;
            rd_r     <= '0;
            cnt_r    <= '0;
          end
        end
        S_SCAN: begin
          if (scan.done) begin
            unique case (mode_r)
              MODE_REG: begin
                hit_r  <= scan.found_v;
                slot_r <= scan.found_v ? found_idx : free_idx;
                if (!slot_ok) begin
                  status_r <= STATUS_FULL;
                end
              end
              MODE_UNREG: hit_r <= scan.found_v;
              default: begin
                hit_r  <= scan.hit_v;
                slot_r <= hit_idx;
              end
            endcase
            off_s   <= walk_s;
            off_e   <= walk_e;
            rw      <= WI_W'(walk_s >> LANE_SH);
            w_last  <= WI_W'((walk_e - 1'b1) >> LANE_SH);
            issuing <= walk_go;
            p_valid <= 1'b0;
          end
        end
        S_WALK: begin
          p_valid <= issuing;
          p_w     <= rw;
          if (issuing) begin
            if (rw == w_last) begin
              issuing <= 1'b0;
            end else begin
              rw <= rw + 1'b1;
            end
          end
          if (p_valid) begin
            if (mode_r == MODE_COUNT) begin
              cnt_r <= cnt_r + OFF_W'(pop);
            end
            if (mode_r == MODE_GET) begin
              rd_r <= ram_rdata[off_s[LANE_SH-1:0]*STATE_W +: STATE_W] & STATE_MASK;
            end
          end
        end
        S_FIN: begin
          p_valid <= 1'b0;
        end
        default: begin
          p_valid <= 1'b0;
        end
      endcase
    end
  end

  assign res_state  = rd_r;
  assign res_count  = LEN_W'(cnt_r);
  assign res_hit    = hit_r;
  assign res_status = status_r;

endmodule

/* rtl/region_shadow_state_table_top.sv */
// top level of the region shadow state table
//
// channel  dir  handshake          tuser       tdata (low bit first)
// s        in   s_tvalid/s_tready  mode[2:0]   addr[47:0] length[60:48] byte_state[62:61]
// m        out  m_tvalid/m_tready  -           state_read[1:0] bad_count[14:2]
//                                              region_hit[15] status[17:16]
//
// an item is taken in idle, then scanned against every slot through the shared compare
// unit, then the 16-state shadow words in its range are walked through the registered
// read of the shadow memory, then the result is handed over
// clear all and unused modes skip the scan and the walk; reset empties the slot table at once
// the result sits in an output register, so the next transfer is taken while it waits
module region_shadow_state_table_top #(
  parameter int REGION_SLOTS     = rsst_pkg::DEF_SLOTS,
  parameter int MAX_REGION_BYTES = rsst_pkg::DEF_MAX_BYTES,
  parameter int ADDR_BITS        = rsst_pkg::DEF_ADDR_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // addr, length, byte_state
  input  logic [2:0]  s_tuser,   // mode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata    // state_read, bad_count, region_hit, status
);
  import rsst_pkg::*;

  localparam int SI_W  = (REGION_SLOTS > 1) ? $clog2(REGION_SLOTS) : 1;
  localparam int OFF_W = $clog2(MAX_REGION_BYTES) + 1;
  localparam int DEPTH = REGION_SLOTS * (MAX_REGION_BYTES / LANES);
  localparam int RA_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  mode_t               in_mode;
  logic [63:0]         addr64;
  logic [ADDR_BITS-1:0] in_addr;
  logic [LEN_W-1:0]    length;
  logic [OFF_W-1:0]    in_len;
  logic                over;
  logic                in_clip;

  slot_cmd_t           cmd;
  logic [SI_W-1:0]     cmd_idx;
  logic [ADDR_BITS-1:0] cmd_addr;
  logic [OFF_W-1:0]    cmd_size;
  scan_res_t           scan;
  logic [SI_W-1:0]     found_idx, free_idx, hit_idx;
  logic [OFF_W-1:0]    hit_size, hit_off;

  logic                ram_we;
  logic [RA_W-1:0]     ram_waddr, ram_raddr;
  logic [WORD_W-1:0]   ram_wdata, ram_rdata;

  logic                res_ready, res_valid, res_hit;
  logic [STATE_W-1:0]  res_state;
  logic [LEN_W-1:0]    res_count;
  logic [STATUS_W-1:0] res_status;

  always_comb begin
    in_mode = mode_t'(s_tuser);
    addr64  = 64'(s_tdata[IN_ADDR_W-1:0]);
    in_addr = addr64[ADDR_BITS-1:0];
    length  = s_tdata[IN_ADDR_W +: LEN_W];
    over    = 32'(length) > 32'(MAX_REGION_BYTES);
    in_len  = over ? OFF_W'(MAX_REGION_BYTES) : OFF_W'(length);
    in_clip = over && (in_mode == MODE_REG || in_mode == MODE_SET_RANGE
                       || in_mode == MODE_COUNT);
  end

  rsst_slots #(
    .SLOTS(REGION_SLOTS), .MAX_BYTES(MAX_REGION_BYTES), .ADDR_BITS(ADDR_BITS)
  ) u_slots (
    .clk(clk), .rst(rst), .cmd(cmd), .cmd_idx(cmd_idx), .cmd_addr(cmd_addr),
    .cmd_size(cmd_size), .res(scan), .found_idx(found_idx), .free_idx(free_idx),
    .hit_idx(hit_idx), .hit_size(hit_size), .hit_off(hit_off)
  );

  rsst_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_shadow (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  rsst_seq #(
    .SLOTS(REGION_SLOTS), .MAX_BYTES(MAX_REGION_BYTES), .ADDR_BITS(ADDR_BITS),
    .RA_W(RA_W)
  ) u_seq (
    .clk(clk), .rst(rst), .in_valid(s_tvalid), .in_ready(s_tready),
    .in_mode(in_mode), .in_addr(in_addr), .in_len(in_len),
    .in_state(s_tdata[IN_ADDR_W+LEN_W +: STATE_W]), .in_clip(in_clip),
    .cmd(cmd), .cmd_idx(cmd_idx), .cmd_addr(cmd_addr), .cmd_size(cmd_size),
    .scan(scan), .found_idx(found_idx), .free_idx(free_idx), .hit_idx(hit_idx),
    .hit_size(hit_size), .hit_off(hit_off),
    .ram_we(ram_we), .ram_waddr(ram_waddr), .ram_wdata(ram_wdata),
    .ram_raddr(ram_raddr), .ram_rdata(ram_rdata),
    .res_ready(res_ready), .res_valid(res_valid), .res_state(res_state),
    .res_count(res_count), .res_hit(res_hit), .res_status(res_status)
  );

  assign res_ready = !m_tvalid || m_tready;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      m_tdata <= {6'b0, res_status, res_hit, res_count, res_state};
    end
  end

endmodule

/* dv/tb_region_shadow_state_table_top.sv */
// self-checking testbench for the region shadow state table with an in-bench predictor
`timescale 1ns / 100ps

module tb_region_shadow_state_table_top;
  import rsst_pkg::*;

  localparam int SLOTS = 8;
  localparam int MAXB = 4096;
  localparam int IDLE_LIMIT = 20000;

  typedef struct packed {
    logic [2:0]  mode;
    logic [47:0] addr;
    logic [12:0] length;
    logic [1:0]  bstate;
  } shadow_op_t;

  typedef struct packed {
    logic [1:0]  state_read;
    logic [12:0] bad_count;
    logic        region_hit;
    logic [1:0]  status;
  } shadow_rsp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [63:0] s_tdata = '0;
  logic [2:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [23:0] m_tdata;

  region_shadow_state_table_top dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  // predictor state
  logic        pv [SLOTS];
  logic [47:0] pbase [SLOTS];
  logic [12:0] psize [SLOTS];
  logic [1:0]  pshadow [SLOTS*MAXB];

  shadow_op_t  pending_ops[$];
  shadow_rsp_t expected_rsps[$];
  logic [47:0] live_bases[$];

  int  send_idle_pct = 36;
  int  recv_idle_pct = 84;
  bit  hold_recv = 1'b0;
  bit  gen_done = 1'b0;
  int  errors = 0;
  int  idle_cycles = 0;

  function automatic int lookup_slot(logic [47:0] a);
    int best;
    best = -1;
    for (int s = 0; s < SLOTS; s++)
      if (pv[s] && a >= pbase[s] && (a - pbase[s]) < psize[s])
        if (best < 0 || pbase[s] < pbase[best]) best = s;
    return best;
  endfunction

  function automatic int find_slot_base(logic [47:0] b);
    for (int s = 0; s < SLOTS; s++)
      if (pv[s] && pbase[s] == b) return s;
    return -1;
  endfunction

  function automatic shadow_rsp_t predict_shadow(shadow_op_t op);
    shadow_rsp_t r;
    int s;
    int len;
    int off;
    r = '0;
    len = op.length;
    if ((op.mode == MODE_REG || op.mode == MODE_SET_RANGE || op.mode == MODE_COUNT)
        && len > MAXB) begin
      len = MAXB;
      r.status = STATUS_CLIP;
    end
    case (op.mode)
      MODE_REG: begin
        s = find_slot_base(op.addr);
        if (s >= 0) begin
          r.region_hit = 1'b1;
        end else begin
          for (int k = SLOTS - 1; k >= 0; k--)
            if (!pv[k]) s = k;
        end
        if (s < 0) begin
          r.status = STATUS_FULL;
        end else begin
          pv[s] = 1'b1;
          pbase[s] = op.addr;
          psize[s] = 13'(len);
          for (int i = 0; i < len; i++) pshadow[s*MAXB+i] = op.bstate;
        end
      end
      MODE_UNREG: begin
        s = find_slot_base(op.addr);
        if (s >= 0) begin
          pv[s] = 1'b0;
          pbase[s] = '0;
          psize[s] = '0;
          r.region_hit = 1'b1;
        end
      end
      MODE_SET_BYTE, MODE_GET: begin
        s = lookup_slot(op.addr);
        if (s >= 0) begin
          r.region_hit = 1'b1;
          off = int'(op.addr - pbase[s]);
          if (op.mode == MODE_GET) r.state_read = pshadow[s*MAXB+off];
          else pshadow[s*MAXB+off] = op.bstate;
        end
      end
      MODE_SET_RANGE, MODE_COUNT: begin
        s = lookup_slot(op.addr);
        if (s >= 0) begin
          r.region_hit = 1'b1;
          off = int'(op.addr - pbase[s]);
          for (int i = 0; i < len && off < psize[s]; i++, off++) begin
            if (op.mode == MODE_SET_RANGE) pshadow[s*MAXB+off] = op.bstate;
            else if (pshadow[s*MAXB+off] != ST_REDZONE) r.bad_count++;
          end
        end
      end
      MODE_CLEAR: begin
        for (int k = 0; k < SLOTS; k++) begin
          pv[k] = 1'b0;
          pbase[k] = '0;
          psize[k] = '0;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic shadow_op_t make_op(int m, logic [47:0] a, int len, int st);
    shadow_op_t op;
    op.mode = 3'(m);
    op.addr = a;
    op.length = 13'(len);
    op.bstate = 2'(st);
    return op;
  endfunction

  function automatic logic [47:0] rand_addr();
    return 48'({$urandom(), $urandom()});
  endfunction

  function automatic int rand_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 5) return $urandom_range(4097, 8191);
    if (p < 10) return $urandom_range(0, 4096);
    if (p < 15) return 0;
    return $urandom_range(1, 96);
  endfunction

  // random item, mostly aimed at registered regions
  function automatic shadow_op_t random_op();
    int m;
    int p;
    logic [47:0] a;
    p = $urandom_range(0, 99);
    m = $urandom_range(0, 99) < 3 ? 7 : $urandom_range(0, 99) < 3 ? 6 : $urandom_range(0, 5);
    if (live_bases.size() > 0 && p < 80)
      a = live_bases[$urandom_range(0, live_bases.size() - 1)] + $urandom_range(0, 110);
    else if (p < 90)
      a = {40'h0, 8'($urandom_range(0, 255))} << 6;
    else
      a = rand_addr();
    if (m == MODE_REG) begin
      if (live_bases.size() > 12) void'(live_bases.pop_front());
      live_bases.push_back(a);
    end
    return make_op(m, a, rand_len(), $urandom_range(0, 3));
  endfunction

  function automatic bit all_idle();
    return pending_ops.size() == 0 && expected_rsps.size() == 0 && !s_tvalid;
  endfunction

  initial begin
    forever #6 clk = ~clk;
  end

  // stimulus
  initial begin
    for (int s = 0; s < SLOTS; s++) begin
      pv[s] = 1'b0;
      pbase[s] = '0;
      psize[s] = '0;
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed
    pending_ops.push_back(make_op(MODE_GET, 48'h100, 0, 0));
    pending_ops.push_back(make_op(MODE_REG, 48'h100, 64, 1));
    pending_ops.push_back(make_op(MODE_REG, 48'hFFFF_FFFF_FFF0, 8191, 3));
    pending_ops.push_back(make_op(MODE_REG, 48'h0, 0, 0));
    pending_ops.push_back(make_op(MODE_REG, 48'h120, 16, 2));
    pending_ops.push_back(make_op(MODE_SET_BYTE, 48'h120, 0, 3));
    pending_ops.push_back(make_op(MODE_GET, 48'h120, 0, 0));
    pending_ops.push_back(make_op(MODE_SET_RANGE, 48'h130, 8191, 2));
    pending_ops.push_back(make_op(MODE_COUNT, 48'h100, 100, 0));
    pending_ops.push_back(make_op(MODE_COUNT, 48'hFFFF_FFFF_FFF0, 4096, 0));
    pending_ops.push_back(make_op(MODE_GET, 48'h13F, 0, 0));
    pending_ops.push_back(make_op(MODE_UNREG, 48'h100, 0, 0));
    pending_ops.push_back(make_op(MODE_UNREG, 48'h100, 0, 0));
    pending_ops.push_back(make_op(MODE_GET, 48'h121, 0, 0));
    for (int i = 0; i < 7; i++)
      pending_ops.push_back(make_op(MODE_REG, 48'h1000 * (i + 2), 4, i & 3));
    pending_ops.push_back(make_op(7, 48'h2000, 5, 1));
    pending_ops.push_back(make_op(MODE_CLEAR, 0, 0, 0));
    pending_ops.push_back(make_op(MODE_GET, 48'h2000, 0, 0));

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = phase == 0 ? 36 : phase == 1 ? 84 : 0;
      recv_idle_pct = phase == 0 ? 84 : phase == 1 ? 36 : 0;
      if (phase == 2) begin
        hold_recv = 1'b1;
        for (int i = 0; i < 8; i++) pending_ops.push_back(random_op());
      end
      for (int i = 0; i < 260; i++) pending_ops.push_back(random_op());
      // sender pause until every result is back
      while (!all_idle()) @(posedge clk);
    end
    gen_done = 1'b1;
  end

  // driver
  always @(posedge clk) begin
    if (!rst) begin
      if (!s_tvalid || s_tready) begin
        if (pending_ops.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          shadow_op_t op;
          op = pending_ops.pop_front();
          s_tvalid <= 1'b1;
          s_tuser <= op.mode;
          s_tdata <= {1'b0, op.bstate, op.length, op.addr};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
      if (s_tvalid && s_tready) begin
        shadow_op_t acc;
        acc = make_op(s_tuser, s_tdata[47:0], s_tdata[60:48], s_tdata[62:61]);
        expected_rsps.push_back(predict_shadow(acc));
      end
    end
  end

  // receiver with one long hold-off
  int hold_count = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (hold_recv && hold_count < 3000) begin
        hold_count <= hold_count + 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= $urandom_range(0, 99) >= recv_idle_pct;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      shadow_rsp_t got;
      shadow_rsp_t exp;
      got.state_read = m_tdata[1:0];
      got.bad_count = m_tdata[14:2];
      got.region_hit = m_tdata[15];
      got.status = m_tdata[17:16];
      if (expected_rsps.size() == 0) begin
        $error("unexpected result transfer %h", m_tdata);
        errors++;
      end else begin
        exp = expected_rsps.pop_front();
        if (got.state_read !== exp.state_read) begin
          $error("state_read exp %0d got %0d", exp.state_read, got.state_read);
          errors++;
        end
        if (got.bad_count !== exp.bad_count) begin
          $error("bad_count exp %0d got %0d", exp.bad_count, got.bad_count);
          errors++;
        end
        if (got.region_hit !== exp.region_hit) begin
          $error("region_hit exp %0d got %0d", exp.region_hit, got.region_hit);
          errors++;
        end
        if (got.status !== exp.status) begin
          $error("status exp %0d got %0d", exp.status, got.status);
          errors++;
        end
      end
    end
  end

  // watchdog and end of run
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL region_shadow_state_table_top");
      $finish;
    end
  end

  initial begin
    wait (gen_done);
    repeat (300) @(posedge clk);
    if (errors == 0 && expected_rsps.size() == 0) begin
      $display("PASS region_shadow_state_table_top");
    end else begin
      $display("FAIL region_shadow_state_table_top");
    end
    $finish;
  end

endmodule
